>>> src/lpl_pkg.sv
// Package for the lookahead peak limiter: sizes, fixed-point constants,
// register indexes and the small types shared by the limiter modules.
// No dependencies.
package lpl_pkg;

  localparam int CHANNELS        = 2;
  localparam int LOOKAHEAD_DEPTH = 64;
  localparam int STREAMS         = 2;
  localparam int SAMPLE_BITS     = 24;

  localparam int STREAM_W   = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int DEPTH_W    = $clog2(LOOKAHEAD_DEPTH);
  localparam int RING_AW    = STREAM_W + DEPTH_W;
  localparam int RING_ENTRIES = STREAMS * LOOKAHEAD_DEPTH;

  localparam int GAIN_FRAC  = 23;
  localparam int GAIN_W     = 24;
  localparam int COEFF_W    = 24;
  localparam int THRESH_W   = 23;
  localparam int MAG_W      = SAMPLE_BITS;
  localparam int QUOT_CNT_W = $clog2(GAIN_FRAC + 1);

  localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [COEFF_W:0]   COEFF_ONE = (COEFF_W + 1)'(1) << COEFF_W;

  // Configuration register indexes
  localparam logic [1:0] CFG_THRESHOLD       = 2'd0;
  localparam logic [1:0] CFG_RELEASE_COEFF   = 2'd1;
  localparam logic [1:0] CFG_BYPASS          = 2'd2;
  localparam logic [1:0] CFG_ACTIVE_CHANNELS = 2'd3;

  localparam logic [THRESH_W-1:0] THRESHOLD_RST = THRESH_W'(7476385);
  localparam logic [COEFF_W-1:0]  RELEASE_RST   = COEFF_W'(16770227);
  localparam logic [1:0]          ACTIVE_RST    = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] ring_word_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [RING_AW-1:0] waddr;
    logic [RING_AW-1:0] raddr;
  } ring_req_t;

  typedef struct packed {
    logic active;
    logic mul_en;
  } lane_ctrl_t;

endpackage

>>> src/lpl_lane.sv
// One channel lane of the limiter: input masking, magnitude for the peak
// search and the gain multiply with rounding and saturation. Uses lpl_pkg.
module lpl_lane (
  input  logic                      clk_i,
  input  lpl_pkg::lane_ctrl_t       ctrl_i,
  input  lpl_pkg::sample_t          sample_i,
  input  lpl_pkg::sample_t          delayed_i,
  input  logic [lpl_pkg::GAIN_W-1:0] gain_i,
  output lpl_pkg::sample_t          masked_o,
  output logic [lpl_pkg::MAG_W-1:0] mag_o,
  output lpl_pkg::sample_t          result_o
);
  import lpl_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
  localparam int RND_W  = PROD_W - GAIN_FRAC;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [RND_W-1:0]  scaled;

  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RND_W-1:0] SAT_LO = -RND_W'(64'sd1 <<< (SAMPLE_BITS - 1));

  // An inactive channel reads as silence for both the peak and the ring.
  assign masked_o = ctrl_i.active ? sample_i : '0;
  assign mag_o    = masked_o[SAMPLE_BITS-1] ? MAG_W'(-masked_o) : MAG_W'(masked_o);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= PROD_W'(delayed_i) * $signed({1'b0, gain_i});
    end
  end

  // Round half up, then clip to the sample range.
  assign prod_rnd = prod_q + PROD_W'(64'sd1 <<< (GAIN_FRAC - 1));
  assign scaled   = prod_rnd[PROD_W-1:GAIN_FRAC];

  always_comb begin
    if (scaled > SAT_HI) begin
      result_o = SAT_HI[SAMPLE_BITS-1:0];
    end else if (scaled < SAT_LO) begin
      result_o = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      result_o = scaled[SAMPLE_BITS-1:0];
    end
  end

endmodule

>>> src/lpl_div.sv
// Restoring divider, one quotient bit per cycle, for threshold * 2^23 / peak.
// Uses lpl_pkg. The dividend is known to be below the divisor.
module lpl_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lpl_pkg::THRESH_W-1:0] dividend_i,
  input  logic [lpl_pkg::MAG_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [lpl_pkg::GAIN_FRAC-1:0] quotient_o
);
  import lpl_pkg::*;

  localparam int REM_W = MAG_W + 1;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [QUOT_CNT_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [MAG_W-1:0]      div_q, div_d;
  logic [GAIN_FRAC-1:0]  quo_q, quo_d;
  logic [REM_W-1:0]      rem_sh;

  assign rem_sh = {rem_q[REM_W-2:0], 1'b0};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = QUOT_CNT_W'(GAIN_FRAC);
      rem_d  = REM_W'(dividend_i);
      div_d  = divisor_i;
      quo_d  = '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, div_q}) begin
        rem_d = rem_sh - {1'b0, div_q};
        quo_d = {quo_q[GAIN_FRAC-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[GAIN_FRAC-2:0], 1'b0};
      end
      cnt_d = cnt_q - QUOT_CNT_W'(1);
      if (cnt_q == QUOT_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef NO_ASSERTIONS
  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < {1'b0, div_q}) else $error("partial remainder not reduced");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("quotient ready without a division");
`endif

endmodule

>>> src/lpl_ring.sv
// Lookahead delay memory shared by all streams, one word per frame, with
// per-entry valid bits so unwritten slots read as silence. Uses lpl_pkg.
module lpl_ring (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lpl_pkg::ring_req_t    req_i,
  input  lpl_pkg::ring_word_t   wdata_i,
  output lpl_pkg::ring_word_t   rdata_o
);
  import lpl_pkg::*;

  ring_word_t                mem [RING_ENTRIES];
  logic [RING_ENTRIES-1:0]   valid_q;
  ring_word_t                rdata_q;
  logic                      rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

>>> src/lookahead_peak_limiter_unit.sv
// Lookahead peak limiter: one stereo frame per request, 63-frame lookahead per stream.
// A frame taken in idle passes the peak state, the divider state when the peak exceeds the
// threshold, then the multiply, gain and apply states to the output state; bypass goes straight to output.
// The next request is taken the cycle after the result is loaded, so the unit does not take a new
// frame before it is through with the last one; a stalled result holds the input off.
// Reset (rst_ni, asynchronous, active low) restores the register defaults, unity gain
// and zero write positions, and marks every lookahead slot empty at once (no clear pass).
module lookahead_peak_limiter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_wdata_i,
  // input frames
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        stream_i,
  input  logic signed [23:0] sample_left_i,
  input  logic signed [23:0] sample_right_i,
  // result frames
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_stream_o,
  output logic signed [23:0] out_left_o,
  output logic signed [23:0] out_right_o,
  output logic [23:0] gain_now_o
);
  import lpl_pkg::*;

  // Sequencer states. A frame walks through them at most once; bypass goes from idle straight
  // to output, and the divider state is skipped when the peak stays at or below the threshold.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PEAK  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_GAIN  = 3'd4;
  localparam logic [2:0] S_APPLY = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [THRESH_W-1:0] threshold_q;
  logic [COEFF_W-1:0]  release_coeff_q;
  logic                bypass_q;
  logic [1:0]          active_channels_q;

  // Frame held for the duration of the work.
  logic [STREAM_W-1:0] stream_q;
  sample_t             samp_q [CHANNELS];
  logic                bypass_item_q;

  // Per-stream state: the gain and the ring write position.
  logic [GAIN_W-1:0]   gain_q [STREAMS];
  logic [DEPTH_W-1:0]  wp_q [STREAMS];

  logic [GAIN_W-1:0]   want_q;
  logic [2*GAIN_W-1:0] rel_q;
  logic [GAIN_W-1:0]   new_gain_q;

  // Result register, which parts the input side from the output side.
  logic                out_valid_q;
  logic [STREAM_W-1:0] out_stream_q;
  sample_t             out_left_q, out_right_q;
  logic [GAIN_W-1:0]   out_gain_q;

  logic                in_accept;
  logic                out_load;
  logic [STREAM_W-1:0] stream_clamped;
  logic [1:0]          nch;

  lane_ctrl_t          lane_ctrl [CHANNELS];
  sample_t             lane_masked [CHANNELS];
  logic [MAG_W-1:0]    lane_mag [CHANNELS];
  sample_t             lane_result [CHANNELS];
  logic [MAG_W-1:0]    peak;

  ring_req_t           ring_req;
  ring_word_t          ring_wdata, ring_rdata;

  logic                div_start, div_done;
  logic [GAIN_FRAC-1:0] div_quotient;

  logic [GAIN_W-1:0]   gain_old;
  logic [DEPTH_W-1:0]  wp_cur, rp_cur;
  logic [COEFF_W:0]    coeff_inv;
  logic [2*GAIN_W:0]   rel_acc;
  logic [COEFF_W:0]    rel_gain;
  logic [GAIN_W-1:0]   gain_next;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // A stream number past the last slot uses the last slot.
  assign stream_clamped = (32'(stream_i) >= STREAMS) ? STREAM_W'(STREAMS - 1)
                                                     : STREAM_W'(stream_i);

  // Channel count: zero acts as one, anything above the lane count as all lanes.
  always_comb begin
    if (active_channels_q == 2'd0) begin
      nch = 2'd1;
    end else if (32'(active_channels_q) > CHANNELS) begin
      nch = 2'(CHANNELS);
    end else begin
      nch = active_channels_q;
    end
  end

  // ---------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q       <= THRESHOLD_RST;
      release_coeff_q   <= RELEASE_RST;
      bypass_q          <= 1'b0;
      active_channels_q <= ACTIVE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD:       threshold_q       <= cfg_wdata_i[THRESH_W-1:0];
        CFG_RELEASE_COEFF:   release_coeff_q   <= cfg_wdata_i[COEFF_W-1:0];
        CFG_BYPASS:          bypass_q          <= cfg_wdata_i[0];
        CFG_ACTIVE_CHANNELS: active_channels_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Channel lanes and the peak merge
  // ---------------------------------------------------------------------
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    assign lane_ctrl[c].active = (c < 32'(nch));
    assign lane_ctrl[c].mul_en = (state_q == S_APPLY);

    lpl_lane u_lane (
      .clk_i     (clk_i),
      .ctrl_i    (lane_ctrl[c]),
      .sample_i  (samp_q[c]),
      .delayed_i (sample_t'(ring_rdata[c])),
      .gain_i    (new_gain_q),
      .masked_o  (lane_masked[c]),
      .mag_o     (lane_mag[c]),
      .result_o  (lane_result[c])
    );

    assign ring_wdata[c] = lane_masked[c];
  end

  // The merge takes the largest magnitude that any lane found.
  always_comb begin
    peak = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (lane_mag[c] > peak) begin
        peak = lane_mag[c];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Lookahead ring: the new frame goes in at the write position while the
  // slot just after it, the oldest frame of the stream, is read out.
  // ---------------------------------------------------------------------
  assign wp_cur = wp_q[stream_q];
  assign rp_cur = (wp_cur == DEPTH_W'(LOOKAHEAD_DEPTH - 1)) ? '0 : wp_cur + DEPTH_W'(1);

  assign ring_req.we    = (state_q == S_PEAK);
  assign ring_req.re    = (state_q == S_PEAK);
  assign ring_req.waddr = {stream_q, wp_cur};
  assign ring_req.raddr = {stream_q, rp_cur};

  lpl_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ring_req),
    .wdata_i (ring_wdata),
    .rdata_o (ring_rdata)
  );

  // ---------------------------------------------------------------------
  // Wanted gain: threshold over peak, only when the peak is above it.
  // ---------------------------------------------------------------------
  assign div_start = (state_q == S_PEAK) && (peak > MAG_W'(threshold_q));

  lpl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (threshold_q),
    .divisor_i  (peak),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // ---------------------------------------------------------------------
  // Gain update. The gain drops straight to a lower wanted gain; otherwise
  // it recovers through the one-pole release, never past the wanted gain.
  // ---------------------------------------------------------------------
  assign gain_old  = gain_q[stream_q];
  assign coeff_inv = COEFF_ONE - {1'b0, release_coeff_q};
  assign rel_acc   = {1'b0, rel_q}
                   + (2*GAIN_W+1)'({coeff_inv, {GAIN_FRAC{1'b0}}})
                   + (2*GAIN_W+1)'(COEFF_ONE >> 1);
  assign rel_gain  = rel_acc[2*GAIN_W:COEFF_W];

  always_comb begin
    if (want_q <= gain_old) begin
      gain_next = want_q;
    end else if (rel_gain > {1'b0, want_q}) begin
      gain_next = want_q;
    end else begin
      gain_next = rel_gain[GAIN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = bypass_q ? S_OUT : S_PEAK;
        end
      end
      S_PEAK:  state_d = div_start ? S_DIV : S_MUL;
      S_DIV: begin
        if (div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL:   state_d = S_GAIN;
      S_GAIN:  state_d = S_APPLY;
      S_APPLY: state_d = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int s = 0; s < STREAMS; s++) begin
        gain_q[s] <= GAIN_ONE;
        wp_q[s]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_GAIN) begin
        gain_q[stream_q] <= gain_next;
        wp_q[stream_q]   <= rp_cur;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stream_q      <= stream_clamped;
      samp_q[0]     <= sample_left_i;
      samp_q[1]     <= sample_right_i;
      bypass_item_q <= bypass_q;
    end
    if (state_q == S_PEAK) begin
      want_q <= GAIN_ONE;
    end else if (div_done) begin
      want_q <= GAIN_W'(div_quotient);
    end
    if (state_q == S_MUL) begin
      rel_q <= (2*GAIN_W)'(release_coeff_q) * (2*GAIN_W)'(gain_old);
    end
    if (state_q == S_GAIN) begin
      new_gain_q <= gain_next;
    end
    if (out_load) begin
      out_stream_q <= stream_q;
      if (bypass_item_q) begin
        out_left_q  <= samp_q[0];
        out_right_q <= samp_q[1];
        out_gain_q  <= GAIN_ONE;
      end else begin
        out_left_q  <= lane_result[0];
        out_right_q <= lane_result[1];
        out_gain_q  <= new_gain_q;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_stream_o = out_stream_q;
  assign out_left_o   = out_left_q;
  assign out_right_o  = out_right_q;
  assign gain_now_o   = out_gain_q;

`ifndef NO_ASSERTIONS
  a_gain_at_most_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> gain_now_o <= GAIN_ONE) else $error("gain above unity");
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV) else $error("divider finished outside its state");
  a_want_at_most_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_GAIN |-> want_q <= GAIN_ONE) else $error("wanted gain above unity");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != S_IDLE) else $error("request accepted but not worked on");
`endif

endmodule
